// ===== sv/brl_pkg.sv =====
// ----------------------------------------------------------------------------
// brl_pkg
// Shared widths, register indexes and the exp(-x) factor table of the beam
// range likelihood pipeline.
// ----------------------------------------------------------------------------
package brl_pkg;

  // Field and datapath widths.
  localparam int RANGE_W   = 24;  // Q8.16 range
  localparam int WORD_W    = 32;  // Q16.16 weight / result
  localparam int EXP_BITS  = 21;  // exp argument bits below the 32.0 cutoff
  localparam int EXP_IN_W  = 40;  // widest exp argument fed to the unit
  localparam int DEN_W     = WORD_W + 1;
  localparam int DIV_NUM_W = DEN_W + 24;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_RANGE_MAX    = 3'd0,
    CFG_HIT_GAIN     = 3'd1,
    CFG_HIT_INV_VAR  = 3'd2,
    CFG_SHORT_RATE   = 3'd3,
    CFG_SHORT_WEIGHT = 3'd4,
    CFG_MAX_WEIGHT   = 3'd5,
    CFG_RAND_DENSITY = 3'd6,
    CFG_PHI_GAIN     = 3'd7
  } cfg_idx_t;

  typedef logic [EXP_BITS-1:0][WORD_W-1:0] exp_tab_t;

  // Shift-and-subtract quotient, used only while the table is built.
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], a[i]};
      if (rem >= {1'b0, b}) begin
        rem    = rem - {1'b0, b};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Factor table: entry b is exp(-2^(b-16)) in Q0.32. Low entries come from a
  // truncating Taylor series in Q0.62, high entries by squaring the one below.
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] n;
    logic [63:0] sq;
    int          k;
    tab = '0;
    for (int b = 0; b <= 16; b++) begin
      k    = 16 - b;
      term = 64'd1 << 62;
      sum  = term;
      n    = 64'd1;
      for (int it = 0; it < 64; it++) begin
        if (term != 64'd0) begin
          term = udiv64(term >> k, n);
          if (n[0]) begin
            sum = sum - term;
          end else begin
            sum = sum + term;
          end
          n = n + 64'd1;
        end
      end
      sq     = (sum + (64'd1 << 29)) >> 30;
      tab[b] = sq[WORD_W-1:0];
    end
    for (int b = 17; b < EXP_BITS; b++) begin
      sq     = ({32'd0, tab[b-1]} * {32'd0, tab[b-1]}) + (64'd1 << 31);
      tab[b] = sq[63:32];
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

// ===== sv/brl_delay.sv =====
// ----------------------------------------------------------------------------
// brl_delay
// Enabled shift line that carries a side value alongside the pipeline.
// ----------------------------------------------------------------------------
module brl_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr_r [N];

  // Shift one place whenever the pipeline advances.
  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d;
      for (int i = 1; i < N; i++) begin
        sr_r[i] <= sr_r[i-1];
      end
    end
  end

  assign q = sr_r[N-1];

endmodule

// ===== sv/brl_sqmul.sv =====
// ----------------------------------------------------------------------------
// brl_sqmul
// Four-stage saturating (k * v * v) >> 32, the Gaussian exponent argument.
// ----------------------------------------------------------------------------
module brl_sqmul (
  input  logic                        clk,
  input  logic                        en,
  input  logic [brl_pkg::WORD_W-1:0]  k,
  input  logic [brl_pkg::RANGE_W-1:0] v,
  output logic [brl_pkg::WORD_W-1:0]  x
);
  import brl_pkg::*;

  logic [2*RANGE_W-1:0]        vv_r;
  logic [WORD_W+RANGE_W-1:0]   plo_r;
  logic [WORD_W+RANGE_W-1:0]   plo2_r;
  logic [RANGE_W-1:0]          vhi_r;
  logic [WORD_W+RANGE_W-1:0]   phi_r;
  logic [WORD_W+2*RANGE_W:0]   sum;
  logic [WORD_W-1:0]           x_r;
  logic [WORD_W-1:0]           x_nxt;

  // The 32 x 48 product is taken as two 32 x 24 halves on separate stages.
  assign sum = (57'(phi_r) << RANGE_W) + 81'(plo2_r);

  always_comb begin
    if (|sum[WORD_W+2*RANGE_W:2*WORD_W]) begin
      x_nxt = '1;
    end else begin
      x_nxt = sum[2*WORD_W-1:WORD_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vv_r   <= (2*RANGE_W)'(v) * (2*RANGE_W)'(v);
      plo_r  <= (WORD_W+RANGE_W)'(k) * (WORD_W+RANGE_W)'(vv_r[RANGE_W-1:0]);
      vhi_r  <= vv_r[2*RANGE_W-1:RANGE_W];
      phi_r  <= (WORD_W+RANGE_W)'(k) * (WORD_W+RANGE_W)'(vhi_r);
      plo2_r <= plo_r;
      x_r    <= x_nxt;
    end
  end

  assign x = x_r;

endmodule

// ===== sv/brl_exp.sv =====
// ----------------------------------------------------------------------------
// brl_exp
// Pipelined exp(-x), x in Q24.16, result in Q1.32: one stage per argument bit.
// ----------------------------------------------------------------------------
module brl_exp (
  input  logic                         clk,
  input  logic                         en,
  input  logic [brl_pkg::EXP_IN_W-1:0] x,
  output logic [brl_pkg::WORD_W:0]     y
);
  import brl_pkg::*;

  logic [WORD_W:0]   r_r [EXP_BITS];
  logic [EXP_BITS-1:0] x_r [EXP_BITS];
  logic              z_r [EXP_BITS];

  for (genvar i = 0; i < EXP_BITS; i++) begin : g_stage
    logic [WORD_W:0]     r_in;
    logic [EXP_BITS-1:0] x_in;
    logic                z_in;
    logic [2*WORD_W+1:0] prod;
    logic [WORD_W:0]     r_nxt;

    if (i == 0) begin : g_first
      assign r_in = {1'b1, {WORD_W{1'b0}}};
      assign x_in = x[EXP_BITS-1:0];
      assign z_in = |x[EXP_IN_W-1:EXP_BITS];
    end else begin : g_next
      assign r_in = r_r[i-1];
      assign x_in = x_r[i-1];
      assign z_in = z_r[i-1];
    end

    // Rounded multiply by this bit's factor when the bit is set.
    assign prod  = (2*WORD_W+2)'(r_in) * (2*WORD_W+2)'(EXP_TAB[i])
                 + ((2*WORD_W+2)'(1) << (WORD_W-1));
    assign r_nxt = x_in[i] ? prod[2*WORD_W:WORD_W] : r_in;

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[i] <= r_nxt;
        x_r[i] <= x_in;
        z_r[i] <= z_in;
      end
    end
  end

  // Arguments of 32.0 and above give zero.
  assign y = z_r[EXP_BITS-1] ? '0 : r_r[EXP_BITS-1];

endmodule

// ===== sv/brl_div.sv =====
// ----------------------------------------------------------------------------
// brl_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module brl_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [brl_pkg::DIV_NUM_W-1:0] num,
  input  logic [brl_pkg::DEN_W-1:0]     den,
  output logic [brl_pkg::DIV_NUM_W-1:0] q
);
  import brl_pkg::*;

  logic [DEN_W-1:0]     rem_r [DIV_NUM_W];
  logic [DIV_NUM_W-1:0] nq_r  [DIV_NUM_W];
  logic [DEN_W-1:0]     den_r [DIV_NUM_W];

  for (genvar i = 0; i < DIV_NUM_W; i++) begin : g_stage
    logic [DEN_W-1:0]     rem_in;
    logic [DIV_NUM_W-1:0] nq_in;
    logic [DEN_W-1:0]     den_in;
    logic [DEN_W:0]       sh;
    logic [DEN_W:0]       diff;
    logic                 ge;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign nq_in  = nq_r[i-1];
      assign den_in = den_r[i-1];
    end

    // Bring down the next numerator bit and try a subtract.
    assign sh   = {rem_in, nq_in[DIV_NUM_W-1]};
    assign diff = sh - (DEN_W+1)'(den_in);
    assign ge   = sh >= (DEN_W+1)'(den_in);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
        nq_r[i]  <= {nq_in[DIV_NUM_W-2:0], ge};
        den_r[i] <= den_in;
      end
    end
  end

  assign q = nq_r[DIV_NUM_W-1];

endmodule

// ===== sv/beam_range_likelihood.sv =====
// Beam range likelihood: one (expected, measured) range beat enters per clock
// unless a held result is stalled at the output. The longest path is the
// short-reading term: two pipelined exp units of 21 stages, a 57-stage
// restoring divider and four partial-product stages. Configuration must be
// written only while the pipeline is empty; a stall at the output while a
// result is held freezes the whole pipeline.
// ----------------------------------------------------------------------------
// beam_range_likelihood
// Fixed-point mixture likelihood of the beam range-finder sensor model.
// ----------------------------------------------------------------------------
module beam_range_likelihood #(
  parameter logic [31:0] PHI_INV_VAR = 32'd32768
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [brl_pkg::RANGE_W-1:0] in_expected_range,
  input  logic [brl_pkg::RANGE_W-1:0] in_measured_range,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [brl_pkg::WORD_W-1:0]  out_likelihood,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [brl_pkg::WORD_W-1:0]  cfg_wdata
);
  import brl_pkg::*;

  localparam int NSTAGE = 86;

  // Configuration registers.
  logic [RANGE_W-1:0] range_max_r;
  logic [WORD_W-1:0]  hit_gain_r, hit_inv_var_r, short_rate_r, short_weight_r;
  logic [WORD_W-1:0]  max_weight_r, rand_density_r, phi_gain_r;
  logic [2*WORD_W-1:0] sprod_r;

  // Pipeline control.
  logic              en;
  logic [NSTAGE-1:0] v_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_likelihood_r;
  logic [WORD_W-1:0] out_likelihood_nxt;

  // Entry stage.
  logic [RANGE_W-1:0] m0_r, s0_r, d0_r;
  logic               inr0_r, short0_r;

  // Hit and phi terms.
  logic [WORD_W-1:0] x_hit, x_phi;
  logic [WORD_W:0]   e_hit, e_phi;
  logic [WORD_W:0]   hp_prod, pp_prod;
  logic [WORD_W-1:0] hit_r, phi_r, hit_d, phi_d;
  logic              inr_d;

  // Short-reading term.
  logic [EXP_IN_W-1:0]  as_r, am_r;
  logic [WORD_W:0]      es, em;
  logic                 short_d22;
  logic [DIV_NUM_W-1:0] num_r;
  logic [DEN_W-1:0]     den_r;
  logic                 sok_r, sok_d;
  logic [DIV_NUM_W-1:0] q;
  logic [WORD_W-1:0]    qlo1_r;
  logic [DIV_NUM_W-WORD_W-1:0] qhi1_r, qhi2_r, qhi3_r;
  logic [120:0]         acc1_r, acc2_r, acc3_r, acc4_r;
  logic [WORD_W-1:0]    short_r, short_nxt;
  logic [WORD_W+1:0]    total;
  logic [WORD_W-1:0]    base;

  // The whole pipeline advances unless a held result is stalled.
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_max_r    <= 24'd1966080;
      hit_gain_r     <= 32'd65536;
      hit_inv_var_r  <= 32'd819200;
      short_rate_r   <= 32'd6554;
      short_weight_r <= 32'd6554;
      max_weight_r   <= 32'd3277;
      rand_density_r <= 32'd109;
      phi_gain_r     <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_RANGE_MAX:    range_max_r    <= cfg_wdata[RANGE_W-1:0];
        CFG_HIT_GAIN:     hit_gain_r     <= cfg_wdata;
        CFG_HIT_INV_VAR:  hit_inv_var_r  <= cfg_wdata;
        CFG_SHORT_RATE:   short_rate_r   <= cfg_wdata;
        CFG_SHORT_WEIGHT: short_weight_r <= cfg_wdata;
        CFG_MAX_WEIGHT:   max_weight_r   <= cfg_wdata;
        CFG_RAND_DENSITY: rand_density_r <= cfg_wdata;
        CFG_PHI_GAIN:     phi_gain_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Weight times rate of the short term; stable once configuration settles.
  always_ff @(posedge clk) begin
    sprod_r <= (2*WORD_W)'(short_weight_r) * (2*WORD_W)'(short_rate_r);
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[NSTAGE-2:0], in_valid};
      out_valid_r <= v_r[NSTAGE-1];
    end
  end

  // Entry stage: register the beat, the difference and the range flags.
  always_ff @(posedge clk) begin
    if (en) begin
      m0_r     <= in_expected_range;
      s0_r     <= in_measured_range;
      d0_r     <= (in_expected_range > in_measured_range) ?
                  in_expected_range - in_measured_range :
                  in_measured_range - in_expected_range;
      inr0_r   <= in_measured_range < range_max_r;
      short0_r <= in_measured_range < in_expected_range;
    end
  end

  // Gaussian hit term and phi term.
  brl_sqmul u_sq_hit (.clk(clk), .en(en), .k(hit_inv_var_r), .v(d0_r), .x(x_hit));
  brl_sqmul u_sq_phi (.clk(clk), .en(en), .k(PHI_INV_VAR), .v(s0_r), .x(x_phi));

  brl_exp u_exp_hit (.clk(clk), .en(en), .x(EXP_IN_W'(x_hit)), .y(e_hit));
  brl_exp u_exp_phi (.clk(clk), .en(en), .x(EXP_IN_W'(x_phi)), .y(e_phi));

  always_comb begin
    logic [2*WORD_W:0] ph;
    logic [2*WORD_W:0] pp;
    ph      = (2*WORD_W+1)'(hit_gain_r) * (2*WORD_W+1)'(e_hit);
    pp      = (2*WORD_W+1)'(phi_gain_r) * (2*WORD_W+1)'(e_phi);
    hp_prod = ph[2*WORD_W:WORD_W];
    pp_prod = pp[2*WORD_W:WORD_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= hp_prod[WORD_W-1:0];
      phi_r <= pp_prod[WORD_W-1:0];
    end
  end

  brl_delay #(.W(WORD_W), .N(59)) u_dl_hit (.clk(clk), .en(en), .d(hit_r), .q(hit_d));
  brl_delay #(.W(WORD_W), .N(59)) u_dl_phi (.clk(clk), .en(en), .d(phi_r), .q(phi_d));
  brl_delay #(.W(1), .N(85)) u_dl_inr (.clk(clk), .en(en), .d(inr0_r), .q(inr_d));

  // Short-reading term: scaled exponent arguments.
  always_ff @(posedge clk) begin
    logic [WORD_W+RANGE_W-1:0] ps;
    logic [WORD_W+RANGE_W-1:0] pm;
    ps = (WORD_W+RANGE_W)'(short_rate_r) * (WORD_W+RANGE_W)'(s0_r);
    pm = (WORD_W+RANGE_W)'(short_rate_r) * (WORD_W+RANGE_W)'(m0_r);
    if (en) begin
      as_r <= ps[WORD_W+RANGE_W-1:16];
      am_r <= pm[WORD_W+RANGE_W-1:16];
    end
  end

  brl_exp u_exp_s (.clk(clk), .en(en), .x(as_r), .y(es));
  brl_exp u_exp_m (.clk(clk), .en(en), .x(am_r), .y(em));

  brl_delay #(.W(1), .N(22)) u_dl_short (.clk(clk), .en(en), .d(short0_r), .q(short_d22));

  // Numerator, denominator and the term's enable; a zero denominator drops it.
  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= {es, 24'd0};
      den_r <= {1'b1, {WORD_W{1'b0}}} - em;
      sok_r <= short_d22 && (em != {1'b1, {WORD_W{1'b0}}});
    end
  end

  brl_div u_div (.clk(clk), .en(en), .num(num_r), .den(den_r), .q(q));

  brl_delay #(.W(1), .N(61)) u_dl_sok (.clk(clk), .en(en), .d(sok_r), .q(sok_d));

  // 64 x 57 product in four 32-bit partial products, one per stage.
  always_ff @(posedge clk) begin
    if (en) begin
      acc1_r <= 121'((2*WORD_W)'(sprod_r[WORD_W-1:0]) * (2*WORD_W)'(q[WORD_W-1:0]));
      qlo1_r <= q[WORD_W-1:0];
      qhi1_r <= q[DIV_NUM_W-1:WORD_W];
      acc2_r <= acc1_r
              + (121'((2*WORD_W)'(sprod_r[2*WORD_W-1:WORD_W]) * (2*WORD_W)'(qlo1_r))
                 << WORD_W);
      qhi2_r <= qhi1_r;
      acc3_r <= acc2_r
              + (121'((2*WORD_W)'(sprod_r[WORD_W-1:0]) * (2*WORD_W)'(qhi2_r)) << WORD_W);
      qhi3_r <= qhi2_r;
      acc4_r <= acc3_r
              + (121'((2*WORD_W)'(sprod_r[2*WORD_W-1:WORD_W]) * (2*WORD_W)'(qhi3_r))
                 << (2*WORD_W));
      short_r <= short_nxt;
    end
  end

  // Shift down by 40 with saturation, then mask with the term's enable.
  always_comb begin
    if (!sok_d) begin
      short_nxt = '0;
    end else if (|acc4_r[120:72]) begin
      short_nxt = '1;
    end else begin
      short_nxt = acc4_r[71:40];
    end
  end

  // Final sum and saturation; the hit term only counts below the maximum range.
  assign base  = inr_d ? rand_density_r : max_weight_r;
  assign total = (WORD_W+2)'(inr_d ? hit_d : {WORD_W{1'b0}}) + (WORD_W+2)'(phi_d)
               + (WORD_W+2)'(short_r) + (WORD_W+2)'(base);
  assign out_likelihood_nxt = (|total[WORD_W+1:WORD_W]) ? '1 : total[WORD_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      out_likelihood_r <= out_likelihood_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_likelihood = out_likelihood_r;

endmodule
